### hdl/four_channel_prescaled_timer_defines.svh
// ----------------------------------------------------------------------------
// Four-channel prescaled timer: assertion macros
// Shared property wrappers for the timer's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef FOUR_CHANNEL_PRESCALED_TIMER_DEFINES_SVH
`define FOUR_CHANNEL_PRESCALED_TIMER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FCPT_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define FCPT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/fcpt_pkg.sv
// ----------------------------------------------------------------------------
// Four-channel prescaled timer package
// Word types, codes, mode bit positions and the count increment function.
// ----------------------------------------------------------------------------
`default_nettype none

package fcpt_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int CHAN_SLOTS   = 4;
    localparam int STEP_W       = 9;
    localparam int SUB_W        = 8;
    localparam int MODE_W       = 12;

    localparam logic [1:0] CMD_READ   = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_CYCLE  = 2'd2;
    localparam logic [1:0] CMD_HBLANK = 2'd3;

    localparam logic [1:0] REG_COUNT   = 2'd0;
    localparam logic [1:0] REG_MODE    = 2'd1;
    localparam logic [1:0] REG_COMPARE = 2'd2;
    localparam logic [1:0] REG_HOLD    = 2'd3;

    localparam logic [1:0] CLK_DIV1   = 2'd0;
    localparam logic [1:0] CLK_DIV16  = 2'd1;
    localparam logic [1:0] CLK_DIV256 = 2'd2;
    localparam logic [1:0] CLK_HBLANK = 2'd3;

    localparam int MODE_ZRET = 6;
    localparam int MODE_CUE  = 7;
    localparam int MODE_CMPE = 8;
    localparam int MODE_OVFE = 9;
    localparam int MODE_EQUF = 10;
    localparam int MODE_OVFF = 11;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  reg_addr;
        logic [31:0] wdata;
        logic [7:0]  cycles;
    } fcpt_in_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic [3:0]  irq_mask;
        logic        bad_access;
    } fcpt_out_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic step;
        logic publish;
    } fcpt_ctl_t;

    typedef struct packed {
        logic busy;
        logic out_full;
    } fcpt_sts_t;

    typedef struct packed {
        logic [15:0]       count;
        logic [MODE_W-1:0] mode;
        logic              irq;
    } fcpt_adv_t;

    function automatic fcpt_adv_t fcpt_advance(input logic [15:0] count,
                                               input logic [15:0] comp,
                                               input logic [MODE_W-1:0] mode);
        fcpt_adv_t   r;
        logic [16:0] nxt;
        nxt    = {1'b0, count} + 17'd1;
        r.count = nxt[15:0];
        r.mode  = mode;
        r.irq   = 1'b0;
        if (nxt == {1'b0, comp}) begin
            if (mode[MODE_CMPE] && !mode[MODE_EQUF]) begin
                r.mode[MODE_EQUF] = 1'b1;
                r.irq             = 1'b1;
            end
            if (mode[MODE_ZRET]) begin
                r.count = 16'd0;
            end
        end else if (nxt[16]) begin
            if (mode[MODE_OVFE] && !mode[MODE_OVFF]) begin
                r.mode[MODE_OVFF] = 1'b1;
                r.irq             = 1'b1;
            end
            r.count = 16'd0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/fcpt_ctrl.sv
// ----------------------------------------------------------------------------
// Four-channel prescaled timer controller
// Sequences capture, execute, increment stepping and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module fcpt_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               m_ready,
    input  wire fcpt_pkg::fcpt_sts_t sts,
    output fcpt_pkg::fcpt_ctl_t     ctl
);
    import fcpt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                ctl.exec   = 1'b1;
                state_next = ST_RUN;
            end
            ST_RUN: begin
                ctl.step = 1'b1;
                if (!sts.busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!sts.out_full || m_ready) begin
                    ctl.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### hdl/fcpt_datapath.sv
// ----------------------------------------------------------------------------
// Four-channel prescaled timer datapath
// Channel registers, per-channel increment lanes and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fcpt_datapath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire fcpt_pkg::fcpt_ctl_t ctl,
    output fcpt_pkg::fcpt_sts_t      sts,
    input  wire fcpt_pkg::fcpt_in_t  s_word,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output fcpt_pkg::fcpt_out_t      m_word
);
    import fcpt_pkg::*;

    logic [15:0]       counter_reg [CHAN_SLOTS];
    logic [15:0]       counter_next[CHAN_SLOTS];
    logic [15:0]       compare_reg [CHAN_SLOTS];
    logic [15:0]       compare_next[CHAN_SLOTS];
    logic [MODE_W-1:0] mode_reg    [CHAN_SLOTS];
    logic [MODE_W-1:0] mode_next   [CHAN_SLOTS];
    logic [SUB_W-1:0]  sub_reg     [CHAN_SLOTS];
    logic [SUB_W-1:0]  sub_next    [CHAN_SLOTS];
    logic [STEP_W-1:0] steps_reg   [CHAN_SLOTS];
    logic [STEP_W-1:0] steps_next  [CHAN_SLOTS];

    fcpt_in_t  item_reg;
    fcpt_in_t  item_next;
    logic [31:0] rdata_reg;
    logic [31:0] rdata_next;
    logic        bad_reg;
    logic        bad_next;
    logic [3:0]  irq_reg;
    logic [3:0]  irq_next;
    fcpt_out_t   out_reg;
    fcpt_out_t   out_next;
    logic        m_valid_reg;
    logic        m_valid_next;

    logic [1:0]  ch;
    logic [1:0]  rsel;
    logic        chan_ok;

    assign ch      = item_reg.reg_addr[3:2];
    assign rsel    = item_reg.reg_addr[1:0];
    assign chan_ok = ({1'b0, ch} < 3'(NUM_CHANNELS));

    always_comb begin
        logic [MODE_W-1:0] m;
        logic [STEP_W-1:0] sc;
        fcpt_adv_t         adv;
        logic              any_steps;

        item_next    = item_reg;
        rdata_next   = rdata_reg;
        bad_next     = bad_reg;
        irq_next     = irq_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        counter_next = counter_reg;
        compare_next = compare_reg;
        mode_next    = mode_reg;
        sub_next     = sub_reg;
        steps_next   = steps_reg;
        m            = '0;
        sc           = '0;
        adv          = '0;
        any_steps    = 1'b0;

        if (ctl.capture) begin
            item_next = s_word;
        end

        if (ctl.exec) begin
            rdata_next = 32'd0;
            bad_next   = 1'b0;
            irq_next   = 4'd0;
            case (item_reg.cmd)
                CMD_READ: begin
                    if (!chan_ok) begin
                        bad_next = 1'b1;
                    end else begin
                        case (rsel)
                            REG_COUNT: rdata_next = {16'd0, counter_reg[ch]};
                            REG_MODE:  rdata_next = {20'd0, mode_reg[ch]};
                            default:   bad_next   = 1'b1;
                        endcase
                    end
                end
                CMD_WRITE: begin
                    if (!chan_ok) begin
                        bad_next = 1'b1;
                    end else begin
                        case (rsel)
                            REG_COUNT: begin
                                counter_next[ch] = item_reg.wdata[15:0];
                            end
                            REG_MODE: begin
                                m = {mode_reg[ch][MODE_OVFF:MODE_EQUF],
                                     item_reg.wdata[MODE_OVFE:0]};
                                if (item_reg.wdata[MODE_EQUF]) begin
                                    m[MODE_EQUF] = 1'b0;
                                end
                                if (item_reg.wdata[MODE_OVFF]) begin
                                    m[MODE_OVFF] = 1'b0;
                                end
                                mode_next[ch] = m;
                                sub_next[ch]  = '0;
                            end
                            REG_COMPARE: begin
                                compare_next[ch] = item_reg.wdata[15:0];
                            end
                            default: begin
                                // hold has no read path: accept and drop
                            end
                        endcase
                    end
                end
                CMD_CYCLE: begin
                    for (int i = 0; i < NUM_CHANNELS; i++) begin
                        if (mode_reg[i][MODE_CUE] && mode_reg[i][1:0] != CLK_HBLANK) begin
                            sc = {1'b0, sub_reg[i]} + {1'b0, item_reg.cycles};
                            case (mode_reg[i][1:0])
                                CLK_DIV1: begin
                                    steps_next[i] = sc;
                                    sub_next[i]   = '0;
                                end
                                CLK_DIV16: begin
                                    steps_next[i] = {4'd0, sc[8:4]};
                                    sub_next[i]   = {4'd0, sc[3:0]};
                                end
                                default: begin
                                    steps_next[i] = {8'd0, sc[8]};
                                    sub_next[i]   = sc[7:0];
                                end
                            endcase
                        end
                    end
                end
                default: begin
                    for (int i = 0; i < NUM_CHANNELS; i++) begin
                        if (mode_reg[i][MODE_CUE] && mode_reg[i][1:0] == CLK_HBLANK) begin
                            steps_next[i] = STEP_W'(1);
                        end
                    end
                end
            endcase
        end

        if (ctl.step) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                if (steps_reg[i] != '0) begin
                    adv             = fcpt_advance(counter_reg[i], compare_reg[i], mode_reg[i]);
                    counter_next[i] = adv.count;
                    mode_next[i]    = adv.mode;
                    irq_next[i]     = irq_reg[i] | adv.irq;
                    steps_next[i]   = steps_reg[i] - STEP_W'(1);
                end
            end
        end

        for (int i = 0; i < NUM_CHANNELS; i++) begin
            any_steps = any_steps | (steps_reg[i] != '0);
        end
        sts.busy     = any_steps;
        sts.out_full = m_valid_reg;

        if (ctl.publish) begin
            out_next.rdata      = rdata_reg;
            out_next.irq_mask   = irq_reg;
            out_next.bad_access = bad_reg;
            m_valid_next        = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            for (int i = 0; i < CHAN_SLOTS; i++) begin
                counter_reg[i] <= '0;
                compare_reg[i] <= '0;
                mode_reg[i]    <= '0;
                sub_reg[i]     <= '0;
                steps_reg[i]   <= '0;
            end
        end else begin
            m_valid_reg  <= m_valid_next;
            counter_reg  <= counter_next;
            compare_reg  <= compare_next;
            mode_reg     <= mode_next;
            sub_reg      <= sub_next;
            steps_reg    <= steps_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg  <= item_next;
        rdata_reg <= rdata_next;
        bad_reg   <= bad_next;
        irq_reg   <= irq_next;
        out_reg   <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = out_reg;

endmodule

`default_nettype wire

### hdl/four_channel_prescaled_timer.sv
// ----------------------------------------------------------------------------
// Four-channel prescaled timer
// Four 16-bit timer channels with compare and overflow interrupts.
// ----------------------------------------------------------------------------
// Each input word is a register read, a register write, a tick of a number of
// clock cycles, or an hblank tick, and yields one result word. A word is
// captured, executed, stepped and then published to the output register, and
// the next word is accepted only after that. A tick keeps stepping until every
// channel has made its count increments for that tick: every channel has its
// own increment lane that applies one increment per cycle, and the largest
// number of increments any single channel makes reaches 255 at /1, 16 at /16
// and 1 at /256 or hblank. A new word is accepted while the previous result
// still waits in the output register; a second result waits until that
// register is free.
`default_nettype none
`include "four_channel_prescaled_timer_defines.svh"

module four_channel_prescaled_timer (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire fcpt_pkg::fcpt_in_t s_word,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output fcpt_pkg::fcpt_out_t     m_word
);
    import fcpt_pkg::*;

    fcpt_ctl_t ctl;
    fcpt_sts_t sts;

    fcpt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    fcpt_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .sts     (sts),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    `FCPT_ASSERT_NEXT(a_accept_blocks, aclk, aresetn, s_valid && s_ready, !s_ready, "accepted word did not block input")
    `FCPT_ASSERT_NOW(a_irq_not_bad, aclk, aresetn, m_valid && (m_word.irq_mask != 4'd0), !m_word.bad_access, "interrupt on a register access")
    `FCPT_ASSERT_NOW(a_rdata_no_irq, aclk, aresetn, m_valid && (m_word.rdata != 32'd0), m_word.irq_mask == 4'd0, "read data with interrupt")

endmodule

`default_nettype wire
